FILE: hdl/timed_decision_queue_core_defines.svh
// ----------------------------------------------------------------------------
// Timed decision queue assertion macros
// Property shorthands for the checker file of the queue core.
// ----------------------------------------------------------------------------
`ifndef TIMED_DECISION_QUEUE_CORE_DEFINES_SVH
`define TIMED_DECISION_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on aclk, disabled while in reset.
`define TDQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, disabled while in reset.
`define TDQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tdq_pkg.sv
// ----------------------------------------------------------------------------
// Timed decision queue package
// Request, response and entry types, field widths and the slot index helper.
// ----------------------------------------------------------------------------
package tdq_pkg;

    localparam int unsigned FRAME_W  = 10;
    localparam int unsigned SUBF_W   = 4;
    localparam int unsigned HANDLE_W = 16;
    localparam int unsigned WINDOW_W = 14;
    localparam int unsigned LIN_W    = 14;
    localparam int unsigned DIFF_W   = 16;
    localparam int unsigned DROP_W   = 5;
    localparam int unsigned TOTAL_W  = 32;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 14'd20;
    localparam logic [DIFF_W-1:0]   SF_CYCLE     = 16'd10240;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef struct packed {
        logic                operation;
        logic [FRAME_W-1:0]  target_frame;
        logic [SUBF_W-1:0]   target_subframe;
        logic [HANDLE_W-1:0] decision_in;
        logic [FRAME_W-1:0]  now_frame;
        logic [SUBF_W-1:0]   now_subframe;
    } tdq_req_t;

    typedef struct packed {
        logic                decision_valid;
        logic [HANDLE_W-1:0] decision_out;
        logic [DROP_W-1:0]   dropped_now;
        logic [TOTAL_W-1:0]  missed_total;
        logic [TOTAL_W-1:0]  decisions_total;
        logic                overflow_seen;
    } tdq_rsp_t;

    typedef struct packed {
        logic [FRAME_W-1:0]  frame;
        logic [SUBF_W-1:0]   subframe;
        logic [HANDLE_W-1:0] handle;
    } tdq_entry_t;

    typedef struct packed {
        logic empty;
        logic last;
        logic full;
    } tdq_fifo_stat_t;

    typedef enum logic [1:0] {
        CLS_RELEASE,
        CLS_DROP,
        CLS_FUTURE
    } tdq_class_t;

    // frame * 10 + subframe, by shift and add
    function automatic logic [LIN_W-1:0] slot_index(
        input logic [FRAME_W-1:0] frame,
        input logic [SUBF_W-1:0]  subframe
    );
        logic [LIN_W-1:0] f_ext;
        f_ext = LIN_W'(frame);
        return (f_ext << 3) + (f_ext << 1) + LIN_W'(subframe);
    endfunction

endpackage

FILE: hdl/tdq_fifo.sv
// ----------------------------------------------------------------------------
// Timed decision queue entry FIFO
// Circular entry memory with head/tail pointers and a registered head read.
// ----------------------------------------------------------------------------
module tdq_fifo #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  tdq_pkg::tdq_entry_t     push_entry,
    input  logic                    pop,
    input  logic                    rd_en,
    output tdq_pkg::tdq_entry_t     rd_entry,
    output tdq_pkg::tdq_fifo_stat_t status
);
    import tdq_pkg::*;

    localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

    tdq_entry_t        store_reg [QUEUE_DEPTH];
    tdq_entry_t        rd_entry_reg;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    always_comb begin
        head_next = pop  ? ptr_inc(head_reg) : head_reg;
        tail_next = push ? ptr_inc(tail_reg) : tail_reg;
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[tail_reg] <= push_entry;
        end
        if (rd_en) begin
            rd_entry_reg <= store_reg[head_reg];
        end
    end

    assign rd_entry     = rd_entry_reg;
    assign status.empty = (fill_reg == '0);
    assign status.last  = (fill_reg == FILL_W'(1));
    assign status.full  = (fill_reg == FILL_W'(QUEUE_DEPTH));

endmodule

FILE: hdl/tdq_class_unit.sv
// ----------------------------------------------------------------------------
// Timed decision queue classify unit
// Two-step compare of the head entry against the current slot and window.
// ----------------------------------------------------------------------------
module tdq_class_unit (
    input  logic                                aclk,
    input  logic                                capture,
    input  tdq_pkg::tdq_entry_t                 entry,
    input  logic [tdq_pkg::FRAME_W-1:0]         now_frame,
    input  logic [tdq_pkg::SUBF_W-1:0]          now_subframe,
    input  logic signed [tdq_pkg::DIFF_W-1:0]   now_base,
    input  logic signed [tdq_pkg::DIFF_W-1:0]   wrap_base,
    input  logic [tdq_pkg::WINDOW_W-1:0]        window,
    output tdq_pkg::tdq_class_t                 cls
);
    import tdq_pkg::*;

    logic [LIN_W-1:0]         tlin_reg;
    logic signed [DIFF_W-1:0] base_reg;
    logic                     feq_reg;
    logic                     seq_reg;
    logic                     slt_reg;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] win_s;

    // step one: target slot, frame/subframe relations, pick the base slot
    always_ff @(posedge aclk) begin
        if (capture) begin
            tlin_reg <= slot_index(entry.frame, entry.subframe);
            feq_reg  <= (entry.frame == now_frame);
            seq_reg  <= (entry.subframe == now_subframe);
            slt_reg  <= (entry.subframe < now_subframe);
            base_reg <= (entry.frame > now_frame) ? now_base : wrap_base;
        end
    end

    // step two: distance ahead and window compare
    always_comb begin
        diff  = $signed({2'b00, tlin_reg}) - base_reg;
        win_s = $signed({2'b00, window});
        if (feq_reg) begin
            if (seq_reg) begin
                cls = CLS_RELEASE;
            end else if (slt_reg) begin
                cls = CLS_DROP;
            end else begin
                cls = CLS_FUTURE;
            end
        end else if (diff > win_s) begin
            cls = CLS_DROP;
        end else begin
            cls = CLS_FUTURE;
        end
    end

endmodule

FILE: hdl/timed_decision_queue_core.sv
// ----------------------------------------------------------------------------
// Timed decision queue core
// FIFO of scheduling decision handles tagged with a target frame/subframe,
// drained on each subframe tick.
// ----------------------------------------------------------------------------
// An arrive request appends the handle to the queue, or, with the queue full,
// drops it and raises the overflow flag. A tick request occupies the block
// while it examines head entries (at most the fill level), in these steps:
// acceptance in ST_IDLE, ST_PREP to form the current slot index, then per
// entry ST_READ for the memory read, ST_STAGE for the first classify step and
// ST_DECIDE for the decision, and ST_DONE to load the response register.
// Entries are examined one at a time, as the entry memory has a single read
// port and there is one classify unit, which every entry passes in turn.
// s_ready is high only between requests; a finished response waits in the
// m_ channel register and does not block the next arrive request, but a tick
// that completes while the previous response is still pending holds in
// ST_DONE until it is taken. Each tick yields exactly one response: the
// released handle if the head matches the current slot, the count of stale or
// out-of-window entries dropped on the way, the saturating missed and total
// counters, and the overflow flag, which is cleared once reported. The
// ahead_window register may be written through the cfg_ channel at any time
// the block is idle; it resets to 20 subframes.
// ----------------------------------------------------------------------------
module timed_decision_queue_core #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  tdq_pkg::tdq_req_t            s_payload,
    output logic                         m_valid,
    input  logic                         m_ready,
    output tdq_pkg::tdq_rsp_t            m_payload,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tdq_pkg::WINDOW_W-1:0] cfg_data
);
    import tdq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_READ,
        ST_STAGE,
        ST_DECIDE,
        ST_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [FRAME_W-1:0]       now_frame_reg, now_frame_next;
    logic [SUBF_W-1:0]        now_subf_reg, now_subf_next;
    logic signed [DIFF_W-1:0] now_base_reg, now_base_next;
    logic signed [DIFF_W-1:0] wrap_base_reg, wrap_base_next;
    logic                     released_reg, released_next;
    logic [HANDLE_W-1:0]      handle_reg, handle_next;
    logic [DROP_W-1:0]        dropped_reg, dropped_next;
    logic [TOTAL_W-1:0]       missed_reg, missed_next;
    logic [TOTAL_W-1:0]       decided_reg, decided_next;
    logic                     overflow_reg, overflow_next;
    logic [WINDOW_W-1:0]      window_reg, window_next;
    logic                     m_valid_reg, m_valid_next;
    tdq_rsp_t                 rsp_reg, rsp_next;

    logic           req_accept;
    logic           fifo_push;
    logic           fifo_pop;
    logic           fifo_rd_en;
    logic           cls_capture;
    tdq_entry_t     push_entry;
    tdq_entry_t     head_entry;
    tdq_fifo_stat_t fifo_stat;
    tdq_class_t     head_cls;
    logic [LIN_W-1:0] now_lin;

    // ---------------------------------------------------------------- queue
    tdq_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (fifo_push),
        .push_entry (push_entry),
        .pop        (fifo_pop),
        .rd_en      (fifo_rd_en),
        .rd_entry   (head_entry),
        .status     (fifo_stat)
    );

    // ------------------------------------------------------ classify unit
    tdq_class_unit u_class (
        .aclk         (aclk),
        .capture      (cls_capture),
        .entry        (head_entry),
        .now_frame    (now_frame_reg),
        .now_subframe (now_subf_reg),
        .now_base     (now_base_reg),
        .wrap_base    (wrap_base_reg),
        .window       (window_reg),
        .cls          (head_cls)
    );

    assign s_ready    = (state_reg == ST_IDLE);
    assign req_accept = s_valid && s_ready;
    assign cfg_ready  = 1'b1;

    assign push_entry.frame    = s_payload.target_frame;
    assign push_entry.subframe = s_payload.target_subframe;
    assign push_entry.handle   = s_payload.decision_in;

    assign fifo_push = req_accept && (s_payload.operation == OP_ARRIVE) && !fifo_stat.full;
    assign now_lin   = slot_index(now_frame_reg, now_subf_reg);

    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    always_comb begin
        state_next     = state_reg;
        now_frame_next = now_frame_reg;
        now_subf_next  = now_subf_reg;
        now_base_next  = now_base_reg;
        wrap_base_next = wrap_base_reg;
        released_next  = released_reg;
        handle_next    = handle_reg;
        dropped_next   = dropped_reg;
        missed_next    = missed_reg;
        decided_next   = decided_reg;
        overflow_next  = overflow_reg;
        window_next    = cfg_valid ? cfg_data : window_reg;
        rsp_next       = rsp_reg;
        fifo_pop       = 1'b0;
        fifo_rd_en     = 1'b0;
        cls_capture    = 1'b0;

        // drop the pending response once the sink takes it
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (req_accept) begin
                    if (s_payload.operation == OP_TICK) begin
                        now_frame_next = s_payload.now_frame;
                        now_subf_next  = s_payload.now_subframe;
                        released_next  = 1'b0;
                        handle_next    = '0;
                        dropped_next   = '0;
                        state_next     = ST_PREP;
                    end else if (fifo_stat.full) begin
                        overflow_next = 1'b1;
                    end
                end
            end
            ST_PREP: begin
                // current slot, and the same slot moved back one SFN cycle
                now_base_next  = $signed({2'b00, now_lin});
                wrap_base_next = $signed({2'b00, now_lin}) - $signed(SF_CYCLE);
                state_next     = fifo_stat.empty ? ST_DONE : ST_READ;
            end
            ST_READ: begin
                fifo_rd_en = 1'b1;
                state_next = ST_STAGE;
            end
            ST_STAGE: begin
                cls_capture = 1'b1;
                state_next  = ST_DECIDE;
            end
            ST_DECIDE: begin
                unique case (head_cls)
                    CLS_RELEASE: begin
                        fifo_pop      = 1'b1;
                        released_next = 1'b1;
                        handle_next   = head_entry.handle;
                        decided_next  = sat_inc(decided_reg);
                        state_next    = ST_DONE;
                    end
                    CLS_DROP: begin
                        fifo_pop     = 1'b1;
                        decided_next = sat_inc(decided_reg);
                        missed_next  = sat_inc(missed_reg);
                        if (dropped_reg != '1) begin
                            dropped_next = dropped_reg + 1'b1;
                        end
                        state_next = fifo_stat.last ? ST_DONE : ST_READ;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_DONE: begin
                // hold until the response register is free
                if (!m_valid_reg || m_ready) begin
                    rsp_next.decision_valid  = released_reg;
                    rsp_next.decision_out    = handle_reg;
                    rsp_next.dropped_now     = dropped_reg;
                    rsp_next.missed_total    = missed_reg;
                    rsp_next.decisions_total = decided_reg;
                    rsp_next.overflow_seen   = overflow_reg;
                    overflow_next            = 1'b0;
                    m_valid_next             = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            missed_reg   <= '0;
            decided_reg  <= '0;
            overflow_reg <= 1'b0;
            window_reg   <= WINDOW_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            missed_reg   <= missed_next;
            decided_reg  <= decided_next;
            overflow_reg <= overflow_next;
            window_reg   <= window_next;
            m_valid_reg  <= m_valid_next;
        end
        now_frame_reg <= now_frame_next;
        now_subf_reg  <= now_subf_next;
        now_base_reg  <= now_base_next;
        wrap_base_reg <= wrap_base_next;
        released_reg  <= released_next;
        handle_reg    <= handle_next;
        dropped_reg   <= dropped_next;
        rsp_reg       <= rsp_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = rsp_reg;

endmodule

FILE: hdl/tdq_checker.sv
// ----------------------------------------------------------------------------
// Timed decision queue port checker
// Port-level properties of the queue core, bound to the top level.
// ----------------------------------------------------------------------------
`include "timed_decision_queue_core_defines.svh"

module tdq_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input tdq_pkg::tdq_req_t            s_payload,
    input logic                         m_valid,
    input logic                         m_ready,
    input tdq_pkg::tdq_rsp_t            m_payload,
    input logic                         cfg_valid,
    input logic                         cfg_ready,
    input logic [tdq_pkg::WINDOW_W-1:0] cfg_data
);
    import tdq_pkg::*;

    `TDQ_ASSERT_NEXT(a_rsp_hold, m_valid && !m_ready, m_valid && $stable(m_payload), "response changed while stalled")

    `TDQ_ASSERT_NOW(a_empty_handle, m_valid && !m_payload.decision_valid, m_payload.decision_out == '0, "empty decision carries a handle")

    `TDQ_ASSERT_NOW(a_missed_le_total, m_valid, m_payload.missed_total <= m_payload.decisions_total, "missed count exceeds decision count")

    `TDQ_ASSERT_NOW(a_dropped_le_missed, m_valid, TOTAL_W'(m_payload.dropped_now) <= m_payload.missed_total, "drops exceed missed count")

    `TDQ_ASSERT_NEXT(a_tick_busy, s_valid && s_ready && (s_payload.operation == OP_TICK), !s_ready, "ready after tick request")

endmodule

bind timed_decision_queue_core tdq_checker u_tdq_checker (.*);
